### rtl/rgb_to_hsv_converter_core_assert.svh
// Assertion macros for the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define R2H_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define R2H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/r2h_pkg.sv
// Shared constants and types of the RGB to HSV converter.
`default_nettype none

package r2h_pkg;

    // Default channel width of the pixel fields.
    localparam int CHANNEL_BITS_DEF = 8;

    // Hue is carried in whole degrees, 0..359.
    localparam int HUE_W      = 9;
    localparam int HUE_SECTOR = 60;
    localparam int HUE_BASE_G = 2 * 60;
    localparam int HUE_BASE_B = 4 * 60;
    localparam int HUE_FULL   = 360;

    // Hue fraction 60*diff/(max-min) never exceeds 60, so six quotient bits.
    localparam int HUE_Q_W = 6;

    // Quotient bits resolved per divider stage.
    localparam int DIV_STEP_BITS = 2;

    // Channel that holds the maximum; red wins ties, then green.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

`default_nettype wire

### rtl/r2h_if.sv
// Valid/ready stream interfaces for RGBA input pixels and HSV output pixels.
`default_nettype none

interface r2h_pix_if #(
    parameter int CHANNEL_BITS = r2h_pkg::CHANNEL_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface r2h_hsv_if #(
    parameter int CHANNEL_BITS = r2h_pkg::CHANNEL_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [r2h_pkg::HUE_W-1:0]   hue_deg;
    logic [CHANNEL_BITS-1:0]     saturation;
    logic [CHANNEL_BITS-1:0]     value_out;
    logic [CHANNEL_BITS-1:0]     alpha_out;

    modport source (output valid, hue_deg, saturation, value_out, alpha_out, input ready);
    modport sink   (input valid, hue_deg, saturation, value_out, alpha_out, output ready);
endinterface

`default_nettype wire

### rtl/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter: pipelined max/min, two dividers, hue assembly.
`default_nettype none

//  Port      Dir  Protocol     Beat payload
//  --------  ---  -----------  ---------------------------------------------
//  i_pix     in   valid/ready  red_in, green_in, blue_in, alpha_in
//  o_hsv     out  valid/ready  hue_deg, saturation, value_out, alpha_out
//
//  One beat in and one beat out per clock when both sides keep up.
//  The restoring dividers resolve two quotient bits per stage.
//  i_rst_n clears only the stage valid bits; payload registers are not reset.
//  Each stage holds while its successor is full and stalled; an empty stage
//  always loads, so bubbles are squeezed out and no beat is lost or doubled.

`include "rgb_to_hsv_converter_core_assert.svh"

module rgb_to_hsv_converter_core #(
    parameter int CHANNEL_BITS = r2h_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    r2h_pix_if.sink    i_pix,
    r2h_hsv_if.source  o_hsv
);

    localparam int CB      = CHANNEL_BITS;
    localparam int STEP    = r2h_pkg::DIV_STEP_BITS;
    localparam int HQ_W    = r2h_pkg::HUE_Q_W;
    localparam int HUE_W   = r2h_pkg::HUE_W;
    localparam int DIV_MAX = (CB > HQ_W) ? CB : HQ_W;
    localparam int DIV_ST  = (DIV_MAX + STEP - 1) / STEP;
    // front, numerators, divider stages, output register
    localparam int NS      = DIV_ST + 3;
    localparam int LAST    = NS - 1;

    localparam logic [CB-1:0]    CH_FULL  = '1;
    localparam logic [HUE_W-1:0] BASE_G   = HUE_W'(r2h_pkg::HUE_BASE_G);
    localparam logic [HUE_W-1:0] BASE_B   = HUE_W'(r2h_pkg::HUE_BASE_B);
    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(r2h_pkg::HUE_FULL);

    typedef struct packed {
        logic [CB-1:0]    red;
        logic [CB-1:0]    green;
        logic [CB-1:0]    blue;
        logic [CB-1:0]    alpha;
        logic [CB-1:0]    mx;
        logic [CB-1:0]    mn;
        r2h_pkg::t_sector sector;
    } t_front;

    // Fields that ride alongside the dividers to the output stage.
    typedef struct packed {
        logic [CB-1:0]    mx;
        logic [CB-1:0]    alpha;
        r2h_pkg::t_sector sector;
        logic             neg;
        logic             grey;
    } t_side;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its successor moves.
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[LAST] = !r_vld[LAST] || o_hsv.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
                n_vld[k] = (k == 0) ? i_pix.valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = adv[0];

    // ------------------------------------------------------------------
    // Front stage: pick the largest channel and the smallest.
    // ------------------------------------------------------------------
    t_front n_front;
    t_front r_front;

    always_comb begin
        n_front.red   = i_pix.red_in;
        n_front.green = i_pix.green_in;
        n_front.blue  = i_pix.blue_in;
        n_front.alpha = i_pix.alpha_in;
        priority if (i_pix.red_in >= i_pix.green_in && i_pix.red_in >= i_pix.blue_in) begin
            n_front.sector = r2h_pkg::SEC_RED;
            n_front.mx     = i_pix.red_in;
        end else if (i_pix.green_in >= i_pix.blue_in) begin
            n_front.sector = r2h_pkg::SEC_GREEN;
            n_front.mx     = i_pix.green_in;
        end else begin
            n_front.sector = r2h_pkg::SEC_BLUE;
            n_front.mx     = i_pix.blue_in;
        end
        n_front.mn = (i_pix.red_in <= i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in < n_front.mn) begin
            n_front.mn = i_pix.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_front <= n_front;
        end
    end

    // ------------------------------------------------------------------
    // Numerator stage: chroma, signed hue difference, divider operands.
    // ------------------------------------------------------------------
    logic [CB-1:0]        chroma;
    logic [CB-1:0]        dif_p;
    logic [CB-1:0]        dif_m;
    logic                 dif_neg;
    logic [CB-1:0]        dif_mag;
    logic [2*CB-1:0]      sat_num;
    logic [CB+HQ_W-1:0]   hue_num;
    t_side                n_side;

    // Divider operands per stage; index 0 is the numerator-stage register,
    // index k+1 is the output of divider stage k.
    logic [CB-1:0]   sat_den [DIV_ST+1];
    logic [CB-1:0]   sat_rem [DIV_ST+1];
    logic [CB-1:0]   sat_nq  [DIV_ST+1];
    logic [CB-1:0]   hue_den [DIV_ST+1];
    logic [CB-1:0]   hue_rem [DIV_ST+1];
    logic [HQ_W-1:0] hue_nq  [DIV_ST+1];
    t_side           r_side  [DIV_ST+1];

    always_comb begin
        chroma = r_front.mx - r_front.mn;
        unique case (r_front.sector)
            r2h_pkg::SEC_RED: begin
                dif_p = r_front.green;
                dif_m = r_front.blue;
            end
            r2h_pkg::SEC_GREEN: begin
                dif_p = r_front.blue;
                dif_m = r_front.red;
            end
            r2h_pkg::SEC_BLUE: begin
                dif_p = r_front.red;
                dif_m = r_front.green;
            end
            default: begin
                dif_p = '0;
                dif_m = '0;
            end
        endcase
        dif_neg = (dif_p < dif_m);
        dif_mag = dif_neg ? (dif_m - dif_p) : (dif_p - dif_m);
        // chroma * full-scale and 60 * |diff|, both by constants
        sat_num = (2*CB)'(chroma) * (2*CB)'(CH_FULL);
        hue_num = (CB+HQ_W)'(dif_mag) * (CB+HQ_W)'(r2h_pkg::HUE_SECTOR);

        n_side.mx     = r_front.mx;
        n_side.alpha  = r_front.alpha;
        n_side.sector = r_front.sector;
        n_side.neg    = dif_neg;
        n_side.grey   = (chroma == '0);
    end

    // Quotients fit their widths, so the upper numerator bits start below
    // the divisor and form the initial partial remainder. Saturation divides
    // by the largest channel, the hue fraction by the chroma.
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            sat_den[0] <= r_front.mx;
            sat_rem[0] <= sat_num[2*CB-1:CB];
            sat_nq[0]  <= sat_num[CB-1:0];
            hue_den[0] <= chroma;
            hue_rem[0] <= hue_num[CB+HQ_W-1:HQ_W];
            hue_nq[0]  <= hue_num[HQ_W-1:0];
            r_side[0]  <= n_side;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: saturation and hue fraction advance side by side.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DIV_ST; k++) begin : g_div
        localparam int SAT_LEFT = CB - k * STEP;
        localparam int HUE_LEFT = HQ_W - k * STEP;
        localparam int SAT_ST   = (SAT_LEFT >= STEP) ? STEP : ((SAT_LEFT > 0) ? SAT_LEFT : 0);
        localparam int HUE_ST   = (HUE_LEFT >= STEP) ? STEP : ((HUE_LEFT > 0) ? HUE_LEFT : 0);

        r2h_div_stage #(
            .DEN_W (CB),
            .QUO_W (CB),
            .STEPS (SAT_ST)
        ) u_sat_div (
            .i_clk (i_clk),
            .i_en  (adv[k+2]),
            .i_den (sat_den[k]),
            .i_rem (sat_rem[k]),
            .i_nq  (sat_nq[k]),
            .o_den (sat_den[k+1]),
            .o_rem (sat_rem[k+1]),
            .o_nq  (sat_nq[k+1])
        );

        r2h_div_stage #(
            .DEN_W (CB),
            .QUO_W (HQ_W),
            .STEPS (HUE_ST)
        ) u_hue_div (
            .i_clk (i_clk),
            .i_en  (adv[k+2]),
            .i_den (hue_den[k]),
            .i_rem (hue_rem[k]),
            .i_nq  (hue_nq[k]),
            .o_den (hue_den[k+1]),
            .o_rem (hue_rem[k+1]),
            .o_nq  (hue_nq[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (adv[k+2]) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the sector base, wrap negative hues, zero grey pixels.
    // ------------------------------------------------------------------
    t_side            fin;
    logic [HUE_W-1:0] hue_frac;
    logic [HUE_W-1:0] hue_base;
    logic [HUE_W-1:0] n_hue;
    logic [CB-1:0]    n_sat;

    logic [HUE_W-1:0] r_hue;
    logic [CB-1:0]    r_sat;
    logic [CB-1:0]    r_val;
    logic [CB-1:0]    r_alpha;

    always_comb begin
        fin      = r_side[DIV_ST];
        hue_frac = HUE_W'(hue_nq[DIV_ST]);
        unique case (fin.sector)
            r2h_pkg::SEC_RED:   hue_base = '0;
            r2h_pkg::SEC_GREEN: hue_base = BASE_G;
            r2h_pkg::SEC_BLUE:  hue_base = BASE_B;
            default:            hue_base = '0;
        endcase
        // Only the red sector can go below zero; fold it by adding a full turn.
        if (fin.neg && fin.sector == r2h_pkg::SEC_RED && hue_frac != '0) begin
            hue_base = HUE_WRAP;
        end
        n_hue = fin.neg ? (hue_base - hue_frac) : (hue_base + hue_frac);
        n_sat = sat_nq[DIV_ST];
        // Grey or black: the chroma divisor was zero, drop the quotients.
        if (fin.grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_val   <= fin.mx;
            r_alpha <= fin.alpha;
        end
    end

    assign o_hsv.valid      = r_vld[LAST];
    assign o_hsv.hue_deg    = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.value_out  = r_val;
    assign o_hsv.alpha_out  = r_alpha;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `R2H_ASSERT_NOW(a_hue_range, i_clk, i_rst_n,
        o_hsv.valid, o_hsv.hue_deg < HUE_WRAP, "hue out of range")
    `R2H_ASSERT_NOW(a_grey_hue, i_clk, i_rst_n,
        o_hsv.valid && o_hsv.saturation == '0, o_hsv.hue_deg == '0,
        "unsaturated pixel with nonzero hue")
    `R2H_ASSERT_NOW(a_black_sat, i_clk, i_rst_n,
        o_hsv.valid && o_hsv.value_out == '0, o_hsv.saturation == '0,
        "black pixel with nonzero saturation")
    `R2H_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n,
        !r_vld[LAST], i_pix.ready, "input stalled with empty output stage")

endmodule

`default_nettype wire

### rtl/r2h_div_stage.sv
// One registered stage of a restoring divider: resolves STEPS quotient bits.
`default_nettype none

module r2h_div_stage #(
    parameter int DEN_W = 8,
    parameter int QUO_W = 8,
    parameter int STEPS = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [DEN_W-1:0] i_rem,
    input  wire logic [QUO_W-1:0] i_nq,
    output      logic [DEN_W-1:0] o_den,
    output      logic [DEN_W-1:0] o_rem,
    output      logic [QUO_W-1:0] o_nq
);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_nq;
    logic [DEN_W-1:0] n_rem;
    logic [QUO_W-1:0] n_nq;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // Shift the next numerator bit into the remainder; subtract when it fits.
    // The quotient bit takes the vacated low end of the numerator register.
    always_comb begin
        n_rem = i_rem;
        n_nq  = i_nq;
        trial = '0;
        qbit  = 1'b0;
        for (int s = 0; s < STEPS; s++) begin
            trial = {n_rem, n_nq[QUO_W-1]};
            qbit  = (trial >= {1'b0, i_den});
            if (qbit) begin
                trial = trial - {1'b0, i_den};
            end
            n_rem = trial[DEN_W-1:0];
            n_nq  = {n_nq[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the RGB to HSV converter core.
`timescale 1ns / 100ps

module testbench;

    import r2h_pkg::*;

    localparam int CH_BITS = CHANNEL_BITS_DEF;
    localparam int CH_FULL = (1 << CH_BITS) - 1;

    // Settle well past the pipeline latency at the end.
    localparam int SETTLE_CYCLES    = 30;
    localparam int RANDOM_PHASES    = 6;
    localparam int PIXELS_PER_PHASE = 184;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [CH_BITS-1:0] sat;
        logic [CH_BITS-1:0] value;
        logic [CH_BITS-1:0] alpha;
    } hsv_t;

    // One pixel waiting to be sent: idle cycles ahead of it, and whether the
    // sender must first wait for the pipeline to drain completely.
    typedef struct {
        pixel_t      pix;
        int unsigned gap;
        bit          drain_first;
    } queued_pixel_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    r2h_pix_if #(.CHANNEL_BITS(CH_BITS)) pix_bus ();
    r2h_hsv_if #(.CHANNEL_BITS(CH_BITS)) hsv_bus ();

    rgb_to_hsv_converter_core #(
        .CHANNEL_BITS (CH_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_hsv   (hsv_bus)
    );

    queued_pixel_t pixels_to_send[$];
    hsv_t          hsv_expected[$];
    int unsigned   mismatch_count = 0;

    // Handshake flags sampled at the rising edge, consumed at the falling edge.
    logic pix_fire = 1'b0;
    logic hsv_fire = 1'b0;

    // Sender state.
    queued_pixel_t tx_next;
    bit            tx_staged   = 1'b0;
    bit            tx_driving  = 1'b0;
    int unsigned   tx_gap_left = 0;

    // Receiver state: the stall ceiling rotates so long bursts and heavy
    // back-pressure both show up.
    int unsigned rx_stall_left = 0;
    int unsigned rx_results    = 0;
    int unsigned rx_ceilings[5] = '{0, 18, 2, 18, 6};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hold every block input at a known value from time zero.
    initial begin
        i_rst_n          = 1'b0;
        pix_bus.valid    = 1'b0;
        pix_bus.red_in   = '0;
        pix_bus.green_in = '0;
        pix_bus.blue_in  = '0;
        pix_bus.alpha_in = '0;
        hsv_bus.ready    = 1'b0;
    end

    // Hue, saturation and value of one pixel, in whole degrees and full-scale
    // channel units. Hue fraction truncates toward zero before the wrap.
    function automatic hsv_t compute_hsv(pixel_t px);
        int      r;
        int      g;
        int      b;
        int      top;
        int      bottom;
        int      span;
        int      base;
        int      diff;
        int      h;
        t_sector sector;
        hsv_t    res;
        r      = px.red;
        g      = px.green;
        b      = px.blue;
        top    = (r > g) ? r : g;
        top    = (top > b) ? top : b;
        bottom = (r < g) ? r : g;
        bottom = (bottom < b) ? bottom : b;
        span   = top - bottom;
        res.value = top[CH_BITS-1:0];
        res.alpha = px.alpha;
        res.sat   = '0;
        res.hue   = '0;
        // Black pixel: no saturation at all.
        if (top != 0) begin
            res.sat = (longint'(span) * CH_FULL) / top;
        end
        // Grey pixel (including black) keeps hue at zero.
        if (span != 0) begin
            // Red wins any tie for the largest channel, then green.
            if (r == top) begin
                sector = SEC_RED;
            end else if (g == top) begin
                sector = SEC_GREEN;
            end else begin
                sector = SEC_BLUE;
            end
            case (sector)
                SEC_RED: begin
                    base = 0;
                    diff = g - b;
                end
                SEC_GREEN: begin
                    base = HUE_BASE_G;
                    diff = b - r;
                end
                default: begin
                    base = HUE_BASE_B;
                    diff = r - g;
                end
            endcase
            h = base + (HUE_SECTOR * diff) / span;
            if (h < 0) begin
                h += HUE_FULL;
            end
            res.hue = h[HUE_W-1:0];
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b,
                                          int unsigned a);
        pixel_t px;
        px.red   = r[CH_BITS-1:0];
        px.green = g[CH_BITS-1:0];
        px.blue  = b[CH_BITS-1:0];
        px.alpha = a[CH_BITS-1:0];
        return px;
    endfunction

    // Draw a pixel; bias part of the draws toward ties, greys and extremes,
    // which uniform draws almost never hit.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned shape;
        int unsigned level;
        int unsigned other;
        px    = make_pixel($urandom_range(0, CH_FULL), $urandom_range(0, CH_FULL),
                           $urandom_range(0, CH_FULL), $urandom_range(0, CH_FULL));
        shape = $urandom_range(0, 9);
        level = $urandom_range(0, CH_FULL);
        other = $urandom_range(0, level);
        case (shape)
            5: begin
                // Two channels tie for the maximum.
                case ($urandom_range(0, 2))
                    0: px = make_pixel(level, level, other, px.alpha);
                    1: px = make_pixel(level, other, level, px.alpha);
                    default: px = make_pixel(other, level, level, px.alpha);
                endcase
            end
            6: px = make_pixel(level, level, level, px.alpha);
            7: px = make_pixel($urandom_range(0, 1) * CH_FULL, $urandom_range(0, 1) * CH_FULL,
                               $urandom_range(0, 1) * CH_FULL, $urandom_range(0, 1) * CH_FULL);
            8: begin
                // Nearly grey: tiny spans stress the divider.
                px = make_pixel(level ^ $urandom_range(0, 1), level ^ $urandom_range(0, 1),
                                level ^ $urandom_range(0, 1), px.alpha);
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: px.red = CH_FULL;
                    1: px.green = CH_FULL;
                    default: px.blue = CH_FULL;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic add_pixel(pixel_t px, int unsigned gap, bit drain_first);
        queued_pixel_t item;
        item.pix         = px;
        item.gap         = gap;
        item.drain_first = drain_first;
        pixels_to_send.push_back(item);
    endtask

    // Sample both handshakes at the rising edge: predict on every accepted
    // input beat, check every accepted output beat against the oldest prediction.
    always @(posedge i_clk) begin
        pix_fire <= i_rst_n && pix_bus.valid && pix_bus.ready;
        hsv_fire <= i_rst_n && hsv_bus.valid && hsv_bus.ready;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            hsv_expected.push_back(compute_hsv(make_pixel(pix_bus.red_in, pix_bus.green_in,
                                                          pix_bus.blue_in, pix_bus.alpha_in)));
        end
        if (i_rst_n && hsv_bus.valid && hsv_bus.ready) begin
            if (hsv_expected.size() == 0) begin
                $error("output beat with no pixel outstanding: hue_deg %0d", hsv_bus.hue_deg);
                mismatch_count++;
            end else begin
                if (hsv_expected[0].hue !== hsv_bus.hue_deg) begin
                    $error("hue_deg: expected %0d, actual %0d",
                           hsv_expected[0].hue, hsv_bus.hue_deg);
                    mismatch_count++;
                end
                if (hsv_expected[0].sat !== hsv_bus.saturation) begin
                    $error("saturation: expected %0d, actual %0d",
                           hsv_expected[0].sat, hsv_bus.saturation);
                    mismatch_count++;
                end
                if (hsv_expected[0].value !== hsv_bus.value_out) begin
                    $error("value_out: expected %0d, actual %0d",
                           hsv_expected[0].value, hsv_bus.value_out);
                    mismatch_count++;
                end
                if (hsv_expected[0].alpha !== hsv_bus.alpha_out) begin
                    $error("alpha_out: expected %0d, actual %0d",
                           hsv_expected[0].alpha, hsv_bus.alpha_out);
                    mismatch_count++;
                end
                void'(hsv_expected.pop_front());
            end
        end
    end

    // Pixel driver: advance at the falling edge. Stage the next pixel, burn its
    // gap, then present it until accepted. Noise sits on the payload while idle.
    always @(negedge i_clk) begin
        if (pix_fire) begin
            tx_driving = 1'b0;
        end
        if (!tx_driving && !tx_staged && pixels_to_send.size() != 0) begin
            tx_next     = pixels_to_send.pop_front();
            tx_staged   = 1'b1;
            tx_gap_left = tx_next.gap;
        end
        if (tx_staged && !tx_driving) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
            end else if (!tx_next.drain_first || hsv_expected.size() == 0) begin
                // Hold off a drain-first pixel until every result is back.
                tx_driving = 1'b1;
                tx_staged  = 1'b0;
            end
        end
        pix_bus.valid <= tx_driving;
        if (tx_driving) begin
            pix_bus.red_in   <= tx_next.pix.red;
            pix_bus.green_in <= tx_next.pix.green;
            pix_bus.blue_in  <= tx_next.pix.blue;
            pix_bus.alpha_in <= tx_next.pix.alpha;
        end else begin
            pix_bus.red_in   <= $urandom_range(0, CH_FULL);
            pix_bus.green_in <= $urandom_range(0, CH_FULL);
            pix_bus.blue_in  <= $urandom_range(0, CH_FULL);
            pix_bus.alpha_in <= $urandom_range(0, CH_FULL);
        end
    end

    // Result sink: after each accepted beat, drop ready for a drawn stall.
    always @(negedge i_clk) begin
        if (hsv_fire) begin
            rx_results++;
            rx_stall_left = $urandom_range(0, rx_ceilings[(rx_results / 97) % 5]);
        end
        if (rx_stall_left > 0) begin
            hsv_bus.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            hsv_bus.ready <= 1'b1;
        end
    end

    initial begin
        int unsigned gap_ceiling[RANDOM_PHASES] = '{0, 18, 3, 18, 0, 8};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels: black, white, greys, primaries, ties, hue wrap,
        // tiny spans and the alpha extremes.
        add_pixel(make_pixel(0, 0, 0, 0), 0, 1'b0);
        add_pixel(make_pixel(CH_FULL, CH_FULL, CH_FULL, CH_FULL), 0, 1'b0);
        add_pixel(make_pixel(128, 128, 128, 77), 0, 1'b0);
        add_pixel(make_pixel(1, 1, 1, 1), 2, 1'b0);
        add_pixel(make_pixel(CH_FULL, 0, 0, CH_FULL), 0, 1'b0);
        add_pixel(make_pixel(0, CH_FULL, 0, 0), 0, 1'b0);
        add_pixel(make_pixel(0, 0, CH_FULL, 170), 0, 1'b0);
        add_pixel(make_pixel(CH_FULL, CH_FULL, 0, 85), 1, 1'b0);
        add_pixel(make_pixel(CH_FULL, 0, CH_FULL, 0), 0, 1'b0);
        add_pixel(make_pixel(0, CH_FULL, CH_FULL, CH_FULL), 0, 1'b0);
        add_pixel(make_pixel(1, 0, 1, 9), 0, 1'b0);
        add_pixel(make_pixel(0, 1, 1, 9), 3, 1'b0);
        add_pixel(make_pixel(CH_FULL, 0, 128, 200), 0, 1'b0);
        add_pixel(make_pixel(CH_FULL, 0, 1, 201), 0, 1'b0);
        add_pixel(make_pixel(1, 0, 0, 3), 0, 1'b0);
        add_pixel(make_pixel(0, 1, 0, 4), 0, 1'b0);
        add_pixel(make_pixel(0, 0, 1, 5), 0, 1'b0);
        add_pixel(make_pixel(CH_FULL, CH_FULL - 1, CH_FULL - 1, 6), 5, 1'b0);
        add_pixel(make_pixel(200, 100, 50, 7), 0, 1'b0);
        add_pixel(make_pixel(50, 200, 100, 8), 0, 1'b0);
        add_pixel(make_pixel(100, 50, 200, 250), 0, 1'b0);
        add_pixel(make_pixel(10, 20, 30, 0), 18, 1'b0);

        // Random phases; each opens after the pipeline has fully drained.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                add_pixel(random_pixel(), $urandom_range(0, gap_ceiling[phase]), n == 0);
            end
        end

        // Wait for the sender to empty and every result to come back.
        while (pixels_to_send.size() != 0 || tx_staged || tx_driving
               || hsv_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && hsv_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
